/* sv/mlo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlo_pkg;

  // fixed-point format of every value
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  // selected root t +- r needs two bits over the data width
  localparam int W_W       = DATA_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [W_W-1:0]    w_t;

  localparam data_t TMAX = data_t'(32'sh7fffffff);
  localparam data_t TMIN = data_t'(32'sh80000000);

  typedef struct packed {
    data_t re;
    data_t im;
  } cplx_t;

  typedef struct packed {
    w_t re;
    w_t im;
  } wcplx_t;

  // one input beat: matrix [[a, b], [c, d]]
  typedef struct packed {
    data_t a_re;
    data_t a_im;
    data_t b_re;
    data_t b_im;
    data_t c_re;
    data_t c_im;
    data_t d_re;
    data_t d_im;
  } mat_t;

  // one result beat
  typedef struct packed {
    data_t length_re;
    data_t length_im;
    data_t ortho_re;
    data_t ortho_im;
    logic  saturated;
  } res_t;

endpackage

`default_nettype wire

/* sv/mlo_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlo_in_if;
  logic           valid;
  logic           ready;
  mlo_pkg::data_t a_re;
  mlo_pkg::data_t a_im;
  mlo_pkg::data_t b_re;
  mlo_pkg::data_t b_im;
  mlo_pkg::data_t c_re;
  mlo_pkg::data_t c_im;
  mlo_pkg::data_t d_re;
  mlo_pkg::data_t d_im;

  modport source (
    output valid, a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im,
    input  ready
  );
  modport sink (
    input  valid, a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mlo_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlo_out_if;
  logic           valid;
  logic           ready;
  mlo_pkg::data_t length_re;
  mlo_pkg::data_t length_im;
  mlo_pkg::data_t ortho_re;
  mlo_pkg::data_t ortho_im;
  logic           saturated;

  modport source (
    output valid, length_re, length_im, ortho_re, ortho_im, saturated,
    input  ready
  );
  modport sink (
    input  valid, length_re, length_im, ortho_re, ortho_im, saturated,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mlo_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

// forms t for both lanes: half trace, and ad + bc rounded to Q(F)
module mlo_prep (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  mlo_pkg::mat_t mat,
  output logic          out_valid,
  output mlo_pkg::cplx_t len_t,
  output mlo_pkg::cplx_t orth_t
);

  localparam int F = mlo_pkg::FRAC_BITS;

  function automatic mlo_pkg::data_t clamp_t(input logic signed [65:0] x);
    mlo_pkg::data_t y;
    if (x > 66'(mlo_pkg::TMAX)) begin
      y = mlo_pkg::TMAX;
    end else if (x < -66'(mlo_pkg::TMAX)) begin
      y = -mlo_pkg::TMAX;
    end else begin
      y = mlo_pkg::data_t'(x);
    end
    return y;
  endfunction

  // stage 1: half trace and the eight real products
  logic                 p1_valid;
  mlo_pkg::cplx_t       p1_len;
  logic signed [63:0]   p_ardr, p_aidi, p_brcr, p_bici;
  logic signed [63:0]   p_ardi, p_aidr, p_brci, p_bicr;
  logic signed [32:0]   half_re, half_im;

  always_comb begin
    half_re = (33'(mat.a_re) + 33'(mat.d_re) + 33'sd1) >>> 1;
    half_im = (33'(mat.a_im) + 33'(mat.d_im) + 33'sd1) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_len.re <= clamp_t(66'(half_re));
      p1_len.im <= clamp_t(66'(half_im));
      p_ardr    <= 64'(mat.a_re) * 64'(mat.d_re);
      p_aidi    <= 64'(mat.a_im) * 64'(mat.d_im);
      p_brcr    <= 64'(mat.b_re) * 64'(mat.c_re);
      p_bici    <= 64'(mat.b_im) * 64'(mat.c_im);
      p_ardi    <= 64'(mat.a_re) * 64'(mat.d_im);
      p_aidr    <= 64'(mat.a_im) * 64'(mat.d_re);
      p_brci    <= 64'(mat.b_re) * 64'(mat.c_im);
      p_bicr    <= 64'(mat.b_im) * 64'(mat.c_re);
    end
  end

  // stage 2: exact sums, round half up, clamp
  logic signed [65:0] sum_re, sum_im;

  always_comb begin
    sum_re = (66'(p_ardr) - 66'(p_aidi) + 66'(p_brcr) - 66'(p_bici)
              + (66'sd1 <<< (F - 1))) >>> F;
    sum_im = (66'(p_ardi) + 66'(p_aidr) + 66'(p_brci) + 66'(p_bicr)
              + (66'sd1 <<< (F - 1))) >>> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_t     <= p1_len;
      orth_t.re <= clamp_t(sum_re);
      orth_t.im <= clamp_t(sum_im);
    end
  end

endmodule

`default_nettype wire

/* sv/mlo_root.sv */
`timescale 1ns / 1ps
`default_nettype none

// selected root w of w^2 - 2tw + 1 = 0, one lane, fully pipelined
module mlo_root (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  mlo_pkg::cplx_t  t,
  output logic            out_valid,
  output mlo_pkg::wcplx_t w
);

  localparam int F  = mlo_pkg::FRAC_BITS;
  localparam int MB = 64;               // bits of the magnitude root
  localparam int XB = 32;               // bits of the component roots
  localparam int NW = F + 2;            // width of a component within +-1.0
  localparam mlo_pkg::w_t ONE_W = mlo_pkg::w_t'(64'sd1 <<< F);

  typedef struct packed {
    logic [65:0] rem;
    logic [63:0] root;
  } sq128_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq64_t;

  typedef struct packed {
    mlo_pkg::cplx_t t;
    logic [63:0]    ua;
    logic           un;
    logic           vn;
  } side_t;

  typedef struct packed {
    mlo_pkg::cplx_t t;
    logic           vn;
  } side2_t;

  // one digit of the restoring square root
  function automatic sq128_t sq128_step(input sq128_t s, input logic [1:0] pair);
    logic [67:0] remt;
    logic [67:0] trial;
    sq128_t      o;
    remt  = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (remt >= trial) begin
      o.rem  = 66'(remt - trial);
      o.root = {s.root[62:0], 1'b1};
    end else begin
      o.rem  = 66'(remt);
      o.root = {s.root[62:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq64_t sq64_step(input sq64_t s, input logic [1:0] pair);
    logic [35:0] remt;
    logic [35:0] trial;
    sq64_t       o;
    remt  = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (remt >= trial) begin
      o.rem  = 34'(remt - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = 34'(remt);
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // |z|^2 > 1, exact
  function automatic logic gt_one(input mlo_pkg::wcplx_t z);
    logic signed [NW-1:0] rs;
    logic signed [NW-1:0] is_;
    logic [2*NW:0]        nsum;
    logic                 gt;
    rs   = z.re[NW-1:0];
    is_  = z.im[NW-1:0];
    nsum = (2*NW+1)'((2*NW+1)'(rs) * (2*NW+1)'(rs) + (2*NW+1)'(is_) * (2*NW+1)'(is_));
    if (z.re > ONE_W || z.re < -ONE_W || z.im > ONE_W || z.im < -ONE_W) begin
      gt = 1'b1;
    end else begin
      gt = nsum > ((2*NW+1)'(1) << (2*F));
    end
    return gt;
  endfunction

  // r1: squares of t
  logic               r1_valid;
  mlo_pkg::cplx_t     r1_t;
  logic signed [63:0] r1_trr, r1_tii, r1_tri;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_t   <= t;
      r1_trr <= 64'(t.re) * 64'(t.re);
      r1_tii <= 64'(t.im) * 64'(t.im);
      r1_tri <= 64'(t.re) * 64'(t.im);
    end
  end

  // r2: u + iv = t*t - 1, split into sign and magnitude
  logic               r2_valid;
  side_t              r2_side;
  logic [63:0]        r2_va;
  logic signed [65:0] u_full;
  logic signed [64:0] v_full;
  logic [63:0]        ua_next, va_next;

  always_comb begin
    u_full  = 66'(r1_trr) - 66'(r1_tii) - (66'sd1 <<< (2 * F));
    v_full  = 65'(r1_tri) <<< 1;
    ua_next = u_full[65] ? 64'(-u_full) : 64'(u_full);
    va_next = v_full[64] ? 64'(-v_full) : 64'(v_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (en) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_side.t  <= r1_t;
      r2_side.ua <= ua_next;
      r2_side.un <= u_full[65];
      r2_side.vn <= v_full[64];
      r2_va      <= va_next;
    end
  end

  // r3: 32x32 partial products of ua^2 and va^2
  logic        r3_valid;
  side_t       r3_side;
  logic [63:0] r3_ahh, r3_all, r3_ahl, r3_bhh, r3_bll, r3_bhl;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else if (en) begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_side <= r2_side;
      r3_ahh  <= 64'(r2_side.ua[63:32]) * 64'(r2_side.ua[63:32]);
      r3_all  <= 64'(r2_side.ua[31:0]) * 64'(r2_side.ua[31:0]);
      r3_ahl  <= 64'(r2_side.ua[63:32]) * 64'(r2_side.ua[31:0]);
      r3_bhh  <= 64'(r2_va[63:32]) * 64'(r2_va[63:32]);
      r3_bll  <= 64'(r2_va[31:0]) * 64'(r2_va[31:0]);
      r3_bhl  <= 64'(r2_va[63:32]) * 64'(r2_va[31:0]);
    end
  end

  // r4: assemble both squares
  logic         r4_valid;
  side_t        r4_side;
  logic [127:0] r4_sqa, r4_sqb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r4_valid <= 1'b0;
    end else if (en) begin
      r4_valid <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_side <= r3_side;
      r4_sqa  <= {r3_ahh, r3_all} + (128'(r3_ahl) << 33);
      r4_sqb  <= {r3_bhh, r3_bll} + (128'(r3_bhl) << 33);
    end
  end

  // r5: |t*t - 1|^2
  logic         r5_valid;
  side_t        r5_side;
  logic [127:0] r5_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      r5_valid <= 1'b0;
    end else if (en) begin
      r5_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_side <= r4_side;
      r5_n    <= r4_sqa + r4_sqb;
    end
  end

  // magnitude square root, one result bit per stage
  logic         sa_valid [MB];
  sq128_t       sa_st    [MB];
  side_t        sa_side  [MB];
  logic [127:0] sa_n     [MB-1];

  for (genvar i = 0; i < MB; i++) begin : g_sqa
    logic         pv;
    sq128_t       pst;
    side_t        pside;
    logic [127:0] pn;

    if (i == 0) begin : g_first
      assign pv    = r5_valid;
      assign pst   = '0;
      assign pside = r5_side;
      assign pn    = r5_n;
    end else begin : g_next
      assign pv    = sa_valid[i-1];
      assign pst   = sa_st[i-1];
      assign pside = sa_side[i-1];
      assign pn    = sa_n[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sa_valid[i] <= 1'b0;
      end else if (en) begin
        sa_valid[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa_st[i]   <= sq128_step(pst, pn[127-2*i -: 2]);
        sa_side[i] <= pside;
      end
    end

    if (i < MB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          sa_n[i] <= pn;
        end
      end
    end
  end

  // r6: halves (m + |u|)/2 and (m - |u|)/2 routed to re and im
  logic        r6_valid;
  side2_t      r6_side;
  logic [63:0] r6_xr, r6_xi;
  logic [64:0] mp_sum;
  logic [63:0] mm_diff;
  logic [63:0] big, small_h;
  logic [63:0] m_val, ua_val;

  always_comb begin
    m_val   = sa_st[MB-1].root;
    ua_val  = sa_side[MB-1].ua;
    mp_sum  = {1'b0, m_val} + {1'b0, ua_val};
    mm_diff = m_val - ua_val;
    big     = mp_sum[64:1];
    small_h = {1'b0, mm_diff[63:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r6_valid <= 1'b0;
    end else if (en) begin
      r6_valid <= sa_valid[MB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6_side.t  <= sa_side[MB-1].t;
      r6_side.vn <= sa_side[MB-1].vn;
      r6_xr      <= sa_side[MB-1].un ? small_h : big;
      r6_xi      <= sa_side[MB-1].un ? big : small_h;
    end
  end

  // component square roots, both in step
  logic        sb_valid [XB];
  sq64_t       sb_re    [XB];
  sq64_t       sb_im    [XB];
  side2_t      sb_side  [XB];
  logic [63:0] sb_xr    [XB-1];
  logic [63:0] sb_xi    [XB-1];

  for (genvar j = 0; j < XB; j++) begin : g_sqb
    logic        pv;
    sq64_t       pre, pim;
    side2_t      pside;
    logic [63:0] pxr, pxi;

    if (j == 0) begin : g_first
      assign pv    = r6_valid;
      assign pre   = '0;
      assign pim   = '0;
      assign pside = r6_side;
      assign pxr   = r6_xr;
      assign pxi   = r6_xi;
    end else begin : g_next
      assign pv    = sb_valid[j-1];
      assign pre   = sb_re[j-1];
      assign pim   = sb_im[j-1];
      assign pside = sb_side[j-1];
      assign pxr   = sb_xr[j-1];
      assign pxi   = sb_xi[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_valid[j] <= 1'b0;
      end else if (en) begin
        sb_valid[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_re[j]   <= sq64_step(pre, pxr[63-2*j -: 2]);
        sb_im[j]   <= sq64_step(pim, pxi[63-2*j -: 2]);
        sb_side[j] <= pside;
      end
    end

    if (j < XB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          sb_xr[j] <= pxr;
          sb_xi[j] <= pxi;
        end
      end
    end
  end

  // r7: both candidates t + r and t - r
  logic               r7_valid;
  mlo_pkg::wcplx_t    r7_sp, r7_sm;
  logic signed [32:0] rr_s, ri_s;
  mlo_pkg::cplx_t     tl;

  always_comb begin
    tl   = sb_side[XB-1].t;
    rr_s = $signed({1'b0, sb_re[XB-1].root});
    ri_s = sb_side[XB-1].vn ? -$signed({1'b0, sb_im[XB-1].root})
                            : $signed({1'b0, sb_im[XB-1].root});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r7_valid <= 1'b0;
    end else if (en) begin
      r7_valid <= sb_valid[XB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r7_sp.re <= mlo_pkg::W_W'(tl.re) + mlo_pkg::W_W'(rr_s);
      r7_sp.im <= mlo_pkg::W_W'(tl.im) + mlo_pkg::W_W'(ri_s);
      r7_sm.re <= mlo_pkg::W_W'(tl.re) - mlo_pkg::W_W'(rr_s);
      r7_sm.im <= mlo_pkg::W_W'(tl.im) - mlo_pkg::W_W'(ri_s);
    end
  end

  // r8: keep t + r when it lies outside the unit circle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= gt_one(r7_sp) ? r7_sp : r7_sm;
    end
  end

  a_mag_covers_u: assert property (@(posedge clk) disable iff (rst)
    sa_valid[MB-1] |-> sa_st[MB-1].root >= sa_side[MB-1].ua)
    else $error("magnitude root below |u|, sideband out of step");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid))
    else $error("root lane moved during a stall");

  a_w_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(w))
    else $error("root lane valid with unknown value");

endmodule

`default_nettype wire

/* sv/mlo_finish.sv */
`timescale 1ns / 1ps
`default_nettype none

// squares the length root, rounds the length and saturates all four values
module mlo_finish (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  mlo_pkg::wcplx_t wl,
  input  mlo_pkg::wcplx_t wo,
  output logic            out_valid,
  output mlo_pkg::res_t   res
);

  localparam int F = mlo_pkg::FRAC_BITS;
  localparam logic [68:0] RHALF = 69'(1) << (F - 1);

  typedef struct packed {
    mlo_pkg::data_t val;
    logic           sat;
  } rsat_t;

  function automatic rsat_t sat32(input mlo_pkg::w_t x);
    rsat_t o;
    if (x > mlo_pkg::W_W'(mlo_pkg::TMAX)) begin
      o.val = mlo_pkg::TMAX;
      o.sat = 1'b1;
    end else if (x < mlo_pkg::W_W'(mlo_pkg::TMIN)) begin
      o.val = mlo_pkg::TMIN;
      o.sat = 1'b1;
    end else begin
      o.val = mlo_pkg::data_t'(x);
      o.sat = 1'b0;
    end
    return o;
  endfunction

  // magnitude in Q(2F) with sign, rounded half up to Q(F)
  function automatic rsat_t round_sat(input logic [67:0] m, input logic neg);
    logic [68:0] x;
    logic [68:0] q;
    logic [68:0] lim;
    rsat_t       o;
    x     = 69'(m) + (neg ? RHALF - 69'(1) : RHALF);
    q     = x >> F;
    lim   = neg ? 69'(33'h080000000) : 69'(33'h07fffffff);
    o.sat = q > lim;
    if (o.sat) begin
      q = lim;
    end
    o.val = neg ? mlo_pkg::data_t'(~q[31:0] + 32'd1) : mlo_pkg::data_t'(q[31:0]);
    return o;
  endfunction

  // f1: magnitudes and their products; ortho saturation
  logic        f1_valid;
  logic [65:0] f1_a, f1_b, f1_c;
  logic        f1_nim;
  rsat_t       f1_ore, f1_oim;
  logic [32:0] mr, mi;
  mlo_pkg::w_t absr, absi;

  always_comb begin
    absr = wl.re[mlo_pkg::W_W-1] ? -wl.re : wl.re;
    absi = wl.im[mlo_pkg::W_W-1] ? -wl.im : wl.im;
    mr   = absr[32:0];
    mi   = absi[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_a   <= 66'(mr) * 66'(mr);
      f1_b   <= 66'(mi) * 66'(mi);
      f1_c   <= 66'(mr) * 66'(mi);
      f1_nim <= (wl.re[mlo_pkg::W_W-1] != wl.im[mlo_pkg::W_W-1])
                && (wl.re != '0) && (wl.im != '0);
      f1_ore <= sat32(wo.re);
      f1_oim <= sat32(wo.im);
    end
  end

  // f2: w*w = (a - b) + i 2c, output register
  logic        nre;
  logic [65:0] mre;
  rsat_t       lre, lim_v;

  always_comb begin
    nre   = f1_b > f1_a;
    mre   = nre ? f1_b - f1_a : f1_a - f1_b;
    lre   = round_sat(68'(mre), nre);
    lim_v = round_sat(68'({f1_c, 1'b0}), f1_nim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.length_re <= lre.val;
      res.length_im <= lim_v.val;
      res.ortho_re  <= f1_ore.val;
      res.ortho_im  <= f1_oim.val;
      res.saturated <= lre.sat | lim_v.sat | f1_ore.sat | f1_oim.sat;
    end
  end

endmodule

`default_nettype wire

/* sv/mobius_length_and_ortho_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Complex translation length and ortho value of a 2x2 complex Q16.16 matrix.
// One matrix beat is taken every cycle unless the output stalls; it passes through
// the prep stages that form t, both root lanes in parallel, then squaring and rounding. The
// depth is set by the 64-stage magnitude square root followed by the 32-stage
// component square roots, one result bit per stage. The whole pipeline holds
// in place while a finished result waits in the output register, so a stall
// drops or repeats nothing; the input is ready whenever the output register is
// empty or being taken. saturated is set when any of the four values clamped.
module mobius_length_and_ortho_core (
  input  logic       clk,
  input  logic       rst,
  mlo_in_if.sink     item,
  mlo_out_if.source  result
);

  logic            en;
  mlo_pkg::mat_t   mat;
  logic            prep_valid;
  mlo_pkg::cplx_t  len_t, orth_t;
  logic            len_valid, orth_valid;
  mlo_pkg::wcplx_t w_len, w_orth;
  mlo_pkg::res_t   res;

  // pipeline advances unless a result is held at the output
  assign en         = !result.valid || result.ready;
  assign item.ready = en;

  assign mat.a_re = item.a_re;
  assign mat.a_im = item.a_im;
  assign mat.b_re = item.b_re;
  assign mat.b_im = item.b_im;
  assign mat.c_re = item.c_re;
  assign mat.c_im = item.c_im;
  assign mat.d_re = item.d_re;
  assign mat.d_im = item.d_im;

  mlo_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item.valid),
    .mat       (mat),
    .out_valid (prep_valid),
    .len_t     (len_t),
    .orth_t    (orth_t)
  );

  mlo_root u_root_len (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .t         (len_t),
    .out_valid (len_valid),
    .w         (w_len)
  );

  mlo_root u_root_orth (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .t         (orth_t),
    .out_valid (orth_valid),
    .w         (w_orth)
  );

  mlo_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (len_valid & orth_valid),
    .wl        (w_len),
    .wo        (w_orth),
    .out_valid (result.valid),
    .res       (res)
  );

  assign result.length_re = res.length_re;
  assign result.length_im = res.length_im;
  assign result.ortho_re  = res.ortho_re;
  assign result.ortho_im  = res.ortho_im;
  assign result.saturated = res.saturated;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result beat present right after reset");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    len_valid == orth_valid)
    else $error("length and ortho lanes out of step");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(res))
    else $error("waiting result beat changed");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mlo_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlo_in_if  item ();
  mlo_out_if result ();

  mobius_length_and_ortho_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  localparam int LATENCY = 108;

  always #5 clk = ~clk;

  res_t   expected_q[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  int     sat_seen = 0;
  bit     idle_enable = 1'b1;
  int     hold_cycles = 0;

  // ------------------------------------------------------------------
  // fixed-point predictor
  // ------------------------------------------------------------------
  localparam longint TLIM = 64'sd2147483647;

  function automatic longint fdiv(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp_t(longint x);
    if (x > TLIM) return TLIM;
    if (x < -TLIM) return -TLIM;
    return x;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  // root of w^2 - 2tw + 1 with |w| > 1 preferred, t - r on a tie
  function automatic void select_root(input longint tr, input longint ti,
                                      output longint wr, output longint wi);
    longint      u, v, rr, ri, sr, si;
    logic [63:0] ua, va, m, big, lil;
    longint      one;
    bit          gt;
    one = 64'sd1 <<< FRAC_BITS;
    u = tr * tr - ti * ti - (64'sd1 <<< (2 * FRAC_BITS));
    v = 2 * tr * ti;
    ua = (u < 0) ? 64'(-u) : 64'(u);
    va = (v < 0) ? 64'(-v) : 64'(v);
    m = isqrt(128'(ua) * 128'(ua) + 128'(va) * 128'(va));
    big = (m >> 1) + (ua >> 1) + (m & ua & 64'd1);
    lil = (m - ua) >> 1;
    rr = longint'(isqrt(128'(u < 0 ? lil : big)));
    ri = longint'(isqrt(128'(u < 0 ? big : lil)));
    if (v < 0) ri = -ri;
    sr = tr + rr;
    si = ti + ri;
    if (sr > one || sr < -one || si > one || si < -one) gt = 1'b1;
    else gt = (sr * sr + si * si) > (64'sd1 <<< (2 * FRAC_BITS));
    if (gt) begin
      wr = sr;
      wi = si;
    end else begin
      wr = tr - rr;
      wi = ti - ri;
    end
  endfunction

  // signed exact Q(2F) value rounded half up to Q(F), then clamped to 32 bits
  function automatic data_t round_clamp(logic signed [129:0] x, ref bit flag);
    logic signed [129:0] q;
    q = (x + (130'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > 130'sd2147483647) begin
      flag = 1'b1;
      return TMAX;
    end
    if (q < -130'sd2147483648) begin
      flag = 1'b1;
      return TMIN;
    end
    return data_t'(q);
  endfunction

  function automatic data_t clamp32(longint x, ref bit flag);
    if (x > TLIM) begin
      flag = 1'b1;
      return TMAX;
    end
    if (x < -TLIM - 1) begin
      flag = 1'b1;
      return TMIN;
    end
    return data_t'(x);
  endfunction

  function automatic res_t predict_length_ortho(mat_t mx);
    res_t                r;
    bit                  flag;
    longint              ar, ai, br, bi, cr, ci, dr, di;
    longint              tr, ti, wr, wi;
    logic signed [129:0] sq_re, sq_im;
    logic signed [129:0] acc_re, acc_im;
    flag = 1'b0;
    ar = mx.a_re; ai = mx.a_im; br = mx.b_re; bi = mx.b_im;
    cr = mx.c_re; ci = mx.c_im; dr = mx.d_re; di = mx.d_im;
    // half trace and its squared root
    tr = clamp_t(fdiv(ar + dr + 1, 1));
    ti = clamp_t(fdiv(ai + di + 1, 1));
    select_root(tr, ti, wr, wi);
    sq_re = 130'(wr) * 130'(wr) - 130'(wi) * 130'(wi);
    sq_im = 130'sd2 * 130'(wr) * 130'(wi);
    r.length_re = round_clamp(sq_re, flag);
    r.length_im = round_clamp(sq_im, flag);
    // ad + bc, sums exact in Q(2F) with room for four full products
    acc_re = 130'(ar) * 130'(dr) - 130'(ai) * 130'(di)
             + 130'(br) * 130'(cr) - 130'(bi) * 130'(ci)
             + (130'sd1 <<< (FRAC_BITS - 1));
    acc_im = 130'(ar) * 130'(di) + 130'(ai) * 130'(dr)
             + 130'(br) * 130'(ci) + 130'(bi) * 130'(cr)
             + (130'sd1 <<< (FRAC_BITS - 1));
    tr = clamp_t(longint'(acc_re >>> FRAC_BITS));
    ti = clamp_t(longint'(acc_im >>> FRAC_BITS));
    select_root(tr, ti, wr, wi);
    r.ortho_re = clamp32(wr, flag);
    r.ortho_im = clamp32(wi, flag);
    r.saturated = flag;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // sender
  // ------------------------------------------------------------------
  initial begin
    item.valid <= 1'b0;
    {item.a_re, item.a_im, item.b_re, item.b_im} <= '0;
    {item.c_re, item.c_im, item.d_re, item.d_im} <= '0;
  end

  task automatic send_matrix(mat_t mx);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.a_re <= mx.a_re; item.a_im <= mx.a_im;
    item.b_re <= mx.b_re; item.b_im <= mx.b_im;
    item.c_re <= mx.c_re; item.c_im <= mx.c_im;
    item.d_re <= mx.d_re; item.d_im <= mx.d_im;
    do @(posedge clk); while (!item.ready);
    expected_q.push_back(predict_length_ortho(mx));
    items_sent++;
  endtask

  function automatic data_t q16(int whole);
    return data_t'(whole <<< FRAC_BITS);
  endfunction

  function automatic data_t rand_value();
    case ($urandom_range(0, 5))
      0: return data_t'($urandom);
      1: return data_t'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff);
      2: return data_t'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh007fffff);
      3: return q16($signed($urandom_range(0, 6)) - 3);
      4: return ($urandom_range(0, 1)) ? TMAX : TMIN;
      default: return data_t'($signed($urandom_range(0, 32'h07ffffff)) - 32'sh03ffffff);
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t mx;
    mx.a_re = rand_value(); mx.a_im = rand_value();
    mx.b_re = rand_value(); mx.b_im = rand_value();
    mx.c_re = rand_value(); mx.c_im = rand_value();
    mx.d_re = rand_value(); mx.d_im = rand_value();
    // in a quarter of the matrices, b and the imaginary part of c are zeroed
    if ($urandom_range(0, 3) == 0) begin
      mx.b_re = '0; mx.b_im = '0; mx.c_im = '0;
    end
    return mx;
  endfunction

  task automatic drain_results();
    item.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // extremes, identity, parabolic and elliptic traces, ties on the unit circle
  task automatic test_directed();
    mat_t mx;
    mat_t corners[$];
    mx = '0; corners.push_back(mx);
    mx = '0; mx.a_re = q16(1); mx.d_re = q16(1); corners.push_back(mx);
    mx = '0; mx.a_re = q16(-1); mx.d_re = q16(-1); corners.push_back(mx);
    mx = '0; mx.a_re = q16(2); mx.d_re = q16(2); corners.push_back(mx);
    mx = '0; mx.a_im = q16(1); mx.d_im = q16(1); corners.push_back(mx);
    mx = '0; mx.a_re = 32'sh8000; mx.d_re = 32'sh8000; corners.push_back(mx);
    mx = '0; mx.a_re = q16(3); mx.d_re = q16(-3); mx.b_re = q16(1);
    mx.c_re = q16(1); corners.push_back(mx);
    mx = {8{TMAX}}; corners.push_back(mx);
    mx = {8{TMIN}}; corners.push_back(mx);
    mx = {TMAX, TMIN, TMAX, TMIN, TMIN, TMAX, TMIN, TMAX}; corners.push_back(mx);
    mx = {8{32'sh00000001}}; corners.push_back(mx);
    mx = {8{32'shffffffff}}; corners.push_back(mx);
    mx = '0; mx.b_re = q16(1); mx.c_re = q16(-1); corners.push_back(mx);
    mx = '0; mx.a_re = q16(1); mx.d_re = q16(1); mx.b_re = q16(1); corners.push_back(mx);
    mx = '0; mx.a_re = q16(500); mx.d_re = q16(500); mx.a_im = q16(-700);
    corners.push_back(mx);
    mx = '0; mx.a_re = 32'sh0000b505; mx.a_im = 32'sh0000b505;
    mx.d_re = 32'sh0000b505; mx.d_im = 32'sh0000b505; corners.push_back(mx);
    mx = '0; mx.a_re = TMAX; mx.d_re = TMAX; corners.push_back(mx);
    mx = '0; mx.a_im = TMIN; mx.d_im = TMIN; corners.push_back(mx);
    mx = {32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
          32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555};
    corners.push_back(mx);
    foreach (corners[i]) send_matrix(corners[i]);
    drain_results();
  endtask

  task automatic test_random(int count);
    repeat (count) send_matrix(rand_matrix());
  endtask

  // receiver holds off long enough to fill the pipeline and stall the input
  task automatic test_backpressure();
    hold_cycles = 3 * LATENCY;
    repeat (250) send_matrix(rand_matrix());
    drain_results();
  endtask

  task automatic test_streaming();
    idle_enable = 1'b0;
    repeat (200) send_matrix(rand_matrix());
  endtask

  // ------------------------------------------------------------------
  // receiver and checker
  // ------------------------------------------------------------------
  initial begin
    result.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result.ready <= 1'b0;
        hold_cycles--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && result.valid && result.ready) begin
      got.length_re = result.length_re;
      got.length_im = result.length_im;
      got.ortho_re  = result.ortho_re;
      got.ortho_im  = result.ortho_im;
      got.saturated = result.saturated;
      results_seen++;
      if (got.saturated) sat_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p, got %p",
                     results_seen, want, got);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    drain_results();
    repeat ($urandom_range(1, 50)) @(posedge clk);
    test_backpressure();
    test_random(150);
    test_streaming();
    drain_results();
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d matrices, checked %0d results, %0d saturated",
             items_sent, results_seen, sat_seen);
    $display("covered extremes, unit-circle ties, long output stalls and full-rate streaming");
    if (mismatches == 0 && expected_q.size() == 0)
      $display("mobius_length_and_ortho_core verification clean");
    else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("mobius_length_and_ortho_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("mobius_length_and_ortho_core verification failed");
    $finish;
  end

endmodule
